// ===== rtl/core/trdf_pkg.sv =====
// Package for the touch report decode filter.
// Holds report and result structs, status codes and configuration indexes.
// No dependencies.
`default_nettype none

package trdf_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW = 10;

  localparam logic [7:0] STATUS_RELEASE = 8'h80;
  localparam logic [7:0] STATUS_ONE = 8'h81;
  localparam logic [7:0] STATUS_TWO = 8'h82;

  localparam logic [CfgIndexW-1:0] CFG_DUAL_POINT_MODE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_MOVE_THRESHOLD = 1'b1;

  localparam logic [CoordW-1:0] THRESHOLD_RESET = 10'd3;
  localparam logic [CoordW-1:0] COORD_RESET = '1;

  typedef enum logic [1:0] {
    EVENT_NONE = 2'd0,
    EVENT_ONE = 2'd1,
    EVENT_TWO = 2'd2,
    EVENT_RELEASE = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] x_one_high;
    logic [7:0] x_one_low;
    logic [7:0] y_one_high;
    logic [7:0] y_one_low;
    logic [7:0] x_two_high;
    logic [7:0] x_two_low;
    logic [7:0] y_two_high;
    logic [7:0] y_two_low;
  } trdf_report_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [CoordW-1:0] point_one_x;
    logic [CoordW-1:0] point_one_y;
    logic [CoordW-1:0] point_two_x;
    logic [CoordW-1:0] point_two_y;
    logic ack_request;
  } trdf_result_t;

  typedef struct packed {
    logic dual_point_mode;
    logic [CoordW-1:0] move_threshold;
  } trdf_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/trdf_cfg.sv =====
// Configuration registers of the touch report decode filter.
// Depends on trdf_pkg.
`default_nettype none

module trdf_cfg
  import trdf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  output trdf_cfg_t                 cfg
);

  trdf_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dual_point_mode <= 1'b0;
      regs.move_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DUAL_POINT_MODE: regs.dual_point_mode <= cfg_data[0];
        CFG_MOVE_THRESHOLD: regs.move_threshold <= cfg_data[CoordW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/trdf_filter.sv =====
// Report decode and movement deadband of the touch report decode filter.
// Holds the last reported point and first-point flag; depends on trdf_pkg.
`default_nettype none

module trdf_filter
  import trdf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   fire,
  input  wire trdf_report_t report,
  input  wire trdf_cfg_t    cfg,
  output trdf_result_t result
);

  logic [CoordW-1:0] last_x, last_x_next;
  logic [CoordW-1:0] last_y, last_y_next;
  logic awaiting_first, awaiting_first_next;

  logic [CoordW-1:0] x1, y1, x2, y2;
  logic [CoordW-1:0] dx, dy;
  logic moved;

  assign x1 = {report.x_one_high[1:0], report.x_one_low};
  assign y1 = {report.y_one_high[1:0], report.y_one_low};
  assign x2 = {report.x_two_high[1:0], report.x_two_low};
  assign y2 = {report.y_two_high[1:0], report.y_two_low};

  assign dx = (x1 >= last_x) ? (x1 - last_x) : (last_x - x1);
  assign dy = (y1 >= last_y) ? (y1 - last_y) : (last_y - y1);
  assign moved = awaiting_first || (dx >= cfg.move_threshold) || (dy >= cfg.move_threshold);

  always_comb begin
    result = '0;
    last_x_next = last_x;
    last_y_next = last_y;
    awaiting_first_next = awaiting_first;
    if (report.status_byte == STATUS_RELEASE) begin
      result.event_kind = EVENT_RELEASE;
      result.ack_request = 1'b1;
      awaiting_first_next = 1'b1;
    end else if (report.status_byte inside {STATUS_ONE, STATUS_TWO}) begin
      if (cfg.dual_point_mode) begin
        result.point_one_x = x1;
        result.point_one_y = y1;
        if (report.status_byte == STATUS_TWO) begin
          result.event_kind = EVENT_TWO;
          result.point_two_x = x2;
          result.point_two_y = y2;
        end else begin
          result.event_kind = EVENT_ONE;
        end
      end else if (moved) begin
        result.event_kind = EVENT_ONE;
        result.point_one_x = x1;
        result.point_one_y = y1;
        last_x_next = x1;
        last_y_next = y1;
        awaiting_first_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= COORD_RESET;
      last_y <= COORD_RESET;
      awaiting_first <= 1'b1;
    end else if (fire) begin
      last_x <= last_x_next;
      last_y <= last_y_next;
      awaiting_first <= awaiting_first_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/touch_report_decode_filter.sv =====
// Touch report decode filter: one raw controller report in, one touch event out.
// Depends on trdf_pkg, trdf_cfg and trdf_filter.
//
// Takes one report per clock while report_stall is low and gives one result per report.
// The report is registered, decoded and filtered in one pass against the last reported
// point, and the result is registered. The result register and the input register are
// the only stages, so a stall on the result side holds the block after at most one more
// report is taken.
// Configuration writes are always accepted, since cfg_ready is tied high, and belong while the block is idle.
`default_nettype none

module touch_report_decode_filter
  import trdf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 report_valid,
  output logic                      report_stall,
  input  wire trdf_report_t         report,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output trdf_result_t              result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  trdf_cfg_t cfg;
  logic stage_valid;
  trdf_report_t stage_report;
  trdf_result_t filt_result;
  logic advance;
  logic fire;

  assign advance = !result_valid || !result_stall;
  assign fire = stage_valid && advance;
  assign report_stall = stage_valid && !advance;

  trdf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trdf_filter u_filter (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .report (stage_report),
    .cfg    (cfg),
    .result (filt_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!stage_valid || advance) begin
      stage_valid <= report_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!stage_valid || advance) && report_valid) begin
      stage_report <= report;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= filt_result;
    end
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for touch_report_decode_filter: random and directed reports,
// predicted results checked in order, configuration changed between phases.
// Depends on trdf_pkg and the RTL of touch_report_decode_filter.

module testbench;
  import trdf_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned PhaseCount = 7;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned HoldAt = 410;
  localparam int unsigned HoldCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic report_valid = 1'b0;
  logic report_stall;
  trdf_report_t report = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  trdf_result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  trdf_report_t pending_reports[$];
  trdf_result_t expected_events[$];
  int unsigned error_count = 0;

  logic dual_mode = 1'b0;
  logic [CoordW-1:0] threshold = THRESHOLD_RESET;
  logic [CoordW-1:0] last_x = COORD_RESET;
  logic [CoordW-1:0] last_y = COORD_RESET;
  logic awaiting_first = 1'b1;

  touch_report_decode_filter u_top (
    .clk(clk),
    .rst(rst),
    .report_valid(report_valid),
    .report_stall(report_stall),
    .report(report),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic trdf_result_t decode_touch(trdf_report_t rpt);
    trdf_result_t res;
    logic [CoordW-1:0] x1, y1, x2, y2, dx, dy;
    res = '0;
    x1 = {rpt.x_one_high[1:0], rpt.x_one_low};
    y1 = {rpt.y_one_high[1:0], rpt.y_one_low};
    x2 = {rpt.x_two_high[1:0], rpt.x_two_low};
    y2 = {rpt.y_two_high[1:0], rpt.y_two_low};
    case (rpt.status_byte)
      STATUS_RELEASE: begin
        res.event_kind = EVENT_RELEASE;
        res.ack_request = 1'b1;
        awaiting_first = 1'b1;
      end
      STATUS_ONE, STATUS_TWO: begin
        if (dual_mode) begin
          res.point_one_x = x1;
          res.point_one_y = y1;
          if (rpt.status_byte == STATUS_TWO) begin
            res.event_kind = EVENT_TWO;
            res.point_two_x = x2;
            res.point_two_y = y2;
          end else begin
            res.event_kind = EVENT_ONE;
          end
        end else begin
          dx = (x1 >= last_x) ? x1 - last_x : last_x - x1;
          dy = (y1 >= last_y) ? y1 - last_y : last_y - y1;
          if (awaiting_first || dx >= threshold || dy >= threshold) begin
            res.event_kind = EVENT_ONE;
            res.point_one_x = x1;
            res.point_one_y = y1;
            last_x = x1;
            last_y = y1;
            awaiting_first = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] high_byte(logic [CoordW-1:0] c);
    return {6'($urandom), c[9:8]};
  endfunction

  function automatic trdf_report_t make_report(logic [7:0] status, logic [CoordW-1:0] x1,
                                               logic [CoordW-1:0] y1, logic [CoordW-1:0] x2,
                                               logic [CoordW-1:0] y2);
    trdf_report_t rpt;
    rpt.status_byte = status;
    rpt.x_one_high = high_byte(x1);
    rpt.x_one_low = x1[7:0];
    rpt.y_one_high = high_byte(y1);
    rpt.y_one_low = y1[7:0];
    rpt.x_two_high = high_byte(x2);
    rpt.x_two_low = x2[7:0];
    rpt.y_two_high = high_byte(y2);
    rpt.y_two_low = y2[7:0];
    return rpt;
  endfunction

  function automatic logic [7:0] pick_status();
    int unsigned r = $urandom_range(0, 99);
    if (r < 35) return STATUS_ONE;
    if (r < 60) return STATUS_TWO;
    if (r < 72) return STATUS_RELEASE;
    return 8'($urandom);
  endfunction

  function automatic logic [CoordW-1:0] nudge(logic [CoordW-1:0] c, int unsigned spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return CoordW'(v);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else begin
      if (report_valid && !report_stall) begin
        expected_events.push_back(decode_touch(report));
      end
      if (!(report_valid && report_stall)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (burst_left > 0 && pending_reports.size() > 0) begin
          report <= pending_reports.pop_front();
          report_valid <= 1'b1;
          burst_left--;
        end else begin
          report_valid <= 1'b0;
          if (burst_left == 0 && gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Receiver: check each transfer, stall on a pattern of its own.
  int unsigned results_seen = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_seg = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    trdf_result_t want;
    logic nxt_stall;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          $display("%0t unexpected result: kind %0d", $time, result.event_kind);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          if (result.event_kind !== want.event_kind)
            note_mismatch("event_kind", want.event_kind, result.event_kind);
          if (result.point_one_x !== want.point_one_x)
            note_mismatch("point_one_x", want.point_one_x, result.point_one_x);
          if (result.point_one_y !== want.point_one_y)
            note_mismatch("point_one_y", want.point_one_y, result.point_one_y);
          if (result.point_two_x !== want.point_two_x)
            note_mismatch("point_two_x", want.point_two_x, result.point_two_x);
          if (result.point_two_y !== want.point_two_y)
            note_mismatch("point_two_y", want.point_two_y, result.point_two_y);
          if (result.ack_request !== want.ack_request)
            note_mismatch("ack_request", want.ack_request, result.ack_request);
        end
      end
      if (!hold_done && results_seen >= HoldAt) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (stall_seg == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_seg = $urandom_range(10, 80);
      end
      stall_seg--;
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else begin
        case (stall_mode)
          0: nxt_stall = 1'b0;
          1: nxt_stall = ($urandom_range(0, 3) == 0);
          2: nxt_stall = 1'($urandom_range(0, 1));
          default: nxt_stall = (stall_seg % 4) < 2;
        endcase
      end
      result_stall <= nxt_stall;
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((report_valid && !report_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    if (idx == CFG_DUAL_POINT_MODE) dual_mode = val[0];
    else threshold = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reports.size() != 0 || expected_events.size() != 0 || report_valid);
    repeat (4) @(posedge clk);
  endtask

  logic phase_dual [PhaseCount] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  int phase_threshold [PhaseCount] = '{3, 0, 1023, 3, -1, 1023, 1};

  initial begin
    logic [CoordW-1:0] cur_x, cur_y;
    logic [7:0] status;
    int unsigned spread, pick, count;
    cur_x = 10'd512;
    cur_y = 10'd512;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_reports.push_back(make_report(STATUS_ONE, 10'd0, 10'd0, 10'd1023, 10'd1023));
    pending_reports.push_back(make_report(STATUS_ONE, 10'd2, 10'd2, 10'd0, 10'd0));
    pending_reports.push_back(make_report(STATUS_ONE, 10'd3, 10'd0, 10'd5, 10'd6));
    pending_reports.push_back(make_report(STATUS_TWO, 10'd3, 10'd1023, 10'd7, 10'd8));
    pending_reports.push_back(make_report(STATUS_TWO, 10'd1023, 10'd1023, 10'd1, 10'd2));
    pending_reports.push_back(make_report(STATUS_ONE, 10'd1021, 10'd1021, 10'd0, 10'd0));
    pending_reports.push_back(make_report(8'h00, 10'd100, 10'd100, 10'd100, 10'd100));
    pending_reports.push_back(make_report(8'hFF, 10'd1023, 10'd1023, 10'd1023, 10'd1023));
    pending_reports.push_back(make_report(8'h7F, 10'd0, 10'd0, 10'd0, 10'd0));
    pending_reports.push_back(make_report(8'h83, 10'd0, 10'd0, 10'd0, 10'd0));
    pending_reports.push_back(make_report(8'h01, 10'd500, 10'd500, 10'd9, 10'd9));
    pending_reports.push_back(make_report(STATUS_RELEASE, 10'd1023, 10'd1023, 10'd1023,
                                          10'd1023));
    pending_reports.push_back(make_report(STATUS_ONE, 10'd1023, 10'd1023, 10'd0, 10'd0));
    pending_reports.push_back(make_report(STATUS_ONE, 10'd1022, 10'd1023, 10'd0, 10'd0));
    pending_reports.push_back(make_report(STATUS_RELEASE, 10'd0, 10'd0, 10'd0, 10'd0));
    pending_reports.push_back(make_report(STATUS_TWO, 10'd600, 10'd400, 10'd300, 10'd200));

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        wait_idle();
        write_reg(CFG_DUAL_POINT_MODE, {9'($urandom), phase_dual[p]});
        if (phase_threshold[p] < 0)
          write_reg(CFG_MOVE_THRESHOLD, CfgDataW'($urandom_range(1, 40)));
        else write_reg(CFG_MOVE_THRESHOLD, CfgDataW'(phase_threshold[p]));
        @(negedge clk);
      end
      count = (p == 0) ? PhaseItems - 20 : PhaseItems;
      for (int i = 0; i < count; i++) begin
        status = pick_status();
        spread = (threshold == 0) ? 4 : ((threshold > 100) ? 200 : 2 * threshold);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          cur_x = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
          cur_y = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        end else if (pick < 25) begin
          cur_x = 10'($urandom);
          cur_y = 10'($urandom);
        end else begin
          cur_x = nudge(cur_x, spread);
          cur_y = nudge(cur_y, spread);
        end
        pending_reports.push_back(make_report(status, cur_x, cur_y, 10'($urandom),
                                              10'($urandom)));
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/trdf_pkg.sv
rtl/core/trdf_cfg.sv
rtl/core/trdf_filter.sv
rtl/core/touch_report_decode_filter.sv
bench/testbench.sv
